// File: rtl/rmq_pkg.sv
// ============================================================================
// rmq_pkg
// Shared widths, the stage record and the integer square root helper for the
// rotation matrix to quaternion pipeline.
// ============================================================================
package rmq_pkg;

    // Root argument a is at most 3*32768+16384 < 2^17; a<<12 fits in 29 bits.
    localparam int unsigned RadW  = 30;
    localparam int unsigned RootW = 15;
    // Numerator d*4096: |d| <= 65536, so magnitude fits in 29 bits.
    localparam int unsigned NumW  = 29;
    localparam int unsigned QuoW  = 30;

    typedef logic signed [15:0] t_q;

    // Square root iteration record: one radicand bit pair per step.
    typedef struct packed {
        logic [RadW-1:0]  rem;
        logic [RootW-1:0] root;
        logic [RadW-1:0]  rad;
    } t_sqrt;

    // Division iteration record: restoring long division, one bit a step.
    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [QuoW-1:0] quo;
        logic [NumW-1:0] num;
    } t_div;

    // Which part holds the root and which the three divided values.
    typedef struct packed {
        logic [1:0] pick;   // 0 = positive trace, 1..3 = i+1
        logic       degen;
        logic [2:0] neg;    // sign of each numerator
    } t_ctl;

    // One digit-recurrence step of the integer square root.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt o;
        logic [RadW-1:0] trial;
        logic [RadW-1:0] cur;
        cur   = {s.rem[RadW-3:0], s.rad[RadW-1 -: 2]};
        trial = RadW'({s.root, 2'b01});
        o.rad = {s.rad[RadW-3:0], 2'b00};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    // One step of restoring division by the root.
    function automatic t_div div_step(input t_div s, input logic [RootW-1:0] d);
        t_div o;
        logic [NumW:0] cur;
        cur   = {s.rem, s.num[NumW-1]};
        o.num = {s.num[NumW-2:0], 1'b0};
        if (cur >= {{(NumW+1-RootW){1'b0}}, d}) begin
            o.rem = NumW'(cur - {{(NumW+1-RootW){1'b0}}, d});
            o.quo = {s.quo[QuoW-2:0], 1'b1};
        end else begin
            o.rem = NumW'(cur);
            o.quo = {s.quo[QuoW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// File: rtl/rmq_front.sv
// ============================================================================
// rmq_front
// Decodes the branch, forms the root argument and the three numerators.
// Purely combinational; the top level registers its result.
// ============================================================================
module rmq_front (
    input  logic signed [15:0]             i_m [9],
    output logic [rmq_pkg::RadW-1:0]       o_rad,
    output logic [rmq_pkg::NumW-1:0]       o_num [3],
    output rmq_pkg::t_ctl                  o_ctl
);

    logic signed [17:0] tr;
    logic signed [18:0] a;
    logic signed [16:0] d [3];
    logic signed [15:0] mii, mjj, mkk;
    logic [1:0] i_sel;

    always_comb begin
        tr = 18'(i_m[0]) + 18'(i_m[4]) + 18'(i_m[8]);
        i_sel = 2'd0;
        if (i_m[4] > i_m[0]) i_sel = 2'd1;
        if (i_m[8] > ((i_sel == 2'd1) ? i_m[4] : i_m[0])) i_sel = 2'd2;
        mii = i_m[0]; mjj = i_m[4]; mkk = i_m[8];
        // Numerators in order: part j, part k, w (or x, y, z for trace case).
        if (tr > 0) begin
            o_ctl.pick = 2'd0;
            a = 19'(tr) + 19'sd16384;
            d[0] = 17'(i_m[7]) - 17'(i_m[5]);
            d[1] = 17'(i_m[2]) - 17'(i_m[6]);
            d[2] = 17'(i_m[3]) - 17'(i_m[1]);
        end else begin
            o_ctl.pick = i_sel + 2'd1;
            case (i_sel)
                2'd0: begin
                    mii = i_m[0]; mjj = i_m[4]; mkk = i_m[8];
                    d[0] = 17'(i_m[1]) + 17'(i_m[3]);
                    d[1] = 17'(i_m[6]) + 17'(i_m[2]);
                    d[2] = 17'(i_m[7]) - 17'(i_m[5]);
                end
                2'd1: begin
                    mii = i_m[4]; mjj = i_m[8]; mkk = i_m[0];
                    d[0] = 17'(i_m[5]) + 17'(i_m[7]);
                    d[1] = 17'(i_m[1]) + 17'(i_m[3]);
                    d[2] = 17'(i_m[2]) - 17'(i_m[6]);
                end
                default: begin
                    mii = i_m[8]; mjj = i_m[0]; mkk = i_m[4];
                    d[0] = 17'(i_m[6]) + 17'(i_m[2]);
                    d[1] = 17'(i_m[5]) + 17'(i_m[7]);
                    d[2] = 17'(i_m[3]) - 17'(i_m[1]);
                end
            endcase
            a = 19'(mii) - 19'(mjj) - 19'(mkk) + 19'sd16384;
        end
        o_ctl.degen = (a <= 0);
        o_rad = o_ctl.degen ? '0 : {a[16:0], 12'd0, 1'b0} >> 1;
        for (int n = 0; n < 3; n++) begin
            o_ctl.neg[n] = d[n][16];
            o_num[n] = {(d[n][16] ? 17'(-d[n]) : 17'(d[n])), 12'd0};
        end
    end

endmodule

// File: rtl/rmq_back.sv
// ============================================================================
// rmq_back
// Rounding, sign restore, saturation and placement of the four parts.
// ============================================================================
module rmq_back (
    input  logic [rmq_pkg::RootW-1:0] i_root,
    input  logic [rmq_pkg::QuoW-1:0]  i_quo [3],
    input  rmq_pkg::t_ctl             i_ctl,
    output rmq_pkg::t_q               o_q [4]
);

    rmq_pkg::t_q v [3];
    rmq_pkg::t_q r;
    logic [rmq_pkg::QuoW:0] sq;

    always_comb begin
        r = 16'(i_root);
        for (int n = 0; n < 3; n++) begin
            // The quotient already includes the half-divisor bias.
            sq = {1'b0, i_quo[n]};
            if (i_ctl.neg[n]) v[n] = (sq > 31'd32768) ? -16'sd32768 : 16'(-sq);
            else              v[n] = (sq > 31'd32767) ? 16'sd32767 : 16'(sq);
        end
        case (i_ctl.pick)
            2'd0: begin o_q[0] = r;    o_q[1] = v[0]; o_q[2] = v[1]; o_q[3] = v[2]; end
            2'd1: begin o_q[0] = v[2]; o_q[1] = r;    o_q[2] = v[0]; o_q[3] = v[1]; end
            2'd2: begin o_q[0] = v[2]; o_q[1] = v[1]; o_q[2] = r;    o_q[3] = v[0]; end
            default: begin o_q[0] = v[2]; o_q[1] = v[0]; o_q[2] = v[1]; o_q[3] = r; end
        endcase
        if (i_ctl.degen) begin
            for (int n = 0; n < 4; n++) o_q[n] = '0;
        end
    end

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// Order: input, square root, numerator bias, division, output register.
// Throughput: one matrix per cycle unless the output stalls; a 15-stage
// square root pipeline and three 30-stage division pipelines, whose first
// stage only carries the biased numerator and whose other 29 stages each take
// one quotient bit. A stall at the output holds every stage together.
// Reset clears all stage valid bits; payload registers are not reset.
// ============================================================================
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a Q2.14 quaternion.
// ============================================================================
module rotation_matrix_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_m00, i_m01, i_m02,
    input  logic signed [15:0] i_m10, i_m11, i_m12,
    input  logic signed [15:0] i_m20, i_m21, i_m22,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_q_w, o_q_x, o_q_y, o_q_z,
    output logic               o_degenerate
);

    localparam int unsigned SqS = rmq_pkg::RootW;
    localparam int unsigned DvS = rmq_pkg::QuoW;
    localparam int unsigned NSt = 1 + SqS + 1 + DvS + 1;

    logic signed [15:0] m [9];
    logic [rmq_pkg::RadW-1:0] f_rad;
    logic [rmq_pkg::NumW-1:0] f_num [3];
    rmq_pkg::t_ctl f_ctl;

    logic [NSt-1:0] r_vld;
    logic adv;

    rmq_pkg::t_sqrt r_sq [SqS+1];
    logic [rmq_pkg::NumW-1:0] r_num [SqS+1][3];
    rmq_pkg::t_ctl r_sctl [SqS+1];

    rmq_pkg::t_div r_dv [DvS+1][3];
    logic [rmq_pkg::RootW-1:0] r_root [DvS+1];
    rmq_pkg::t_ctl r_dctl [DvS+1];

    rmq_pkg::t_q b_q [4];
    rmq_pkg::t_q r_q [4];
    logic r_degen;

    assign m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};
    // Whole pipeline moves when the output slot is empty or being taken.
    assign adv = !r_vld[NSt-1] || i_ready;
    assign o_ready = adv;

    rmq_front u_front (.i_m(m), .o_rad(f_rad), .o_num(f_num), .o_ctl(f_ctl));

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSt-2:0], i_valid};
        end
    end

    // Square root stages, numerators carried alongside.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0]   <= '{rem: '0, root: '0, rad: f_rad};
            r_num[0]  <= f_num;
            r_sctl[0] <= f_ctl;
            for (int s = 0; s < SqS; s++) begin
                r_sq[s+1]   <= rmq_pkg::sqrt_step(r_sq[s]);
                r_num[s+1]  <= r_num[s];
                r_sctl[s+1] <= r_sctl[s];
            end
        end
    end

    // Division stages; numerator biased by half the root for rounding.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_root[0] <= r_sq[SqS].root;
            r_dctl[0] <= r_sctl[SqS];
            for (int n = 0; n < 3; n++) begin
                r_dv[0][n] <= '{rem: '0, quo: '0,
                    num: r_num[SqS][n] + rmq_pkg::NumW'(r_sq[SqS].root >> 1)};
            end
            for (int s = 0; s < DvS; s++) begin
                r_root[s+1] <= r_root[s];
                r_dctl[s+1] <= r_dctl[s];
                for (int n = 0; n < 3; n++) begin
                    r_dv[s+1][n] <= (s < DvS - rmq_pkg::NumW) ? r_dv[s][n] :
                        rmq_pkg::div_step(r_dv[s][n], r_root[s]);
                end
            end
        end
    end

    logic [rmq_pkg::QuoW-1:0] quo [3];
    always_comb begin
        for (int n = 0; n < 3; n++) quo[n] = r_dv[DvS][n].quo;
    end

    rmq_back u_back (.i_root(r_root[DvS]), .i_quo(quo), .i_ctl(r_dctl[DvS]), .o_q(b_q));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q     <= b_q;
            r_degen <= r_dctl[DvS].degen;
        end
    end

    assign o_valid      = r_vld[NSt-1];
    assign o_q_w        = r_q[0];
    assign o_q_x        = r_q[1];
    assign o_q_y        = r_q[2];
    assign o_q_z        = r_q[3];
    assign o_degenerate = r_degen;

endmodule
